[hdl/cps_pkg.sv]
// shared types and constants of the critical pair scheduler
`default_nettype none
package cps_pkg;

   localparam int NUMBER_W = 7;
   localparam int QCOUNT_W = 13;

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_FILL   = 2'd2,
      CMD_TAKE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_FULL     = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_ADD,
      OP_TAKE_EMPTY,
      OP_SCAN_INIT,
      OP_RMP_CMP,
      OP_RMA_CMP,
      OP_RMP_END,
      OP_RMA_END,
      OP_MG_CMP,
      OP_MG_END,
      OP_PR_INIT,
      OP_OUT_RD,
      OP_OUT_CAP,
      OP_B_INC,
      OP_IN_RD,
      OP_IN_ROW,
      OP_IN_PUSH,
      OP_TAKE_RD,
      OP_TAKE_CAP,
      OP_DONE_WR,
      OP_RESULT
   } op_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DISPATCH,
      S_ADD,
      S_RMP_INIT,
      S_RMP_RD,
      S_RMP_CMP,
      S_RMA_INIT,
      S_RMA_RD,
      S_RMA_CMP,
      S_MG_INIT,
      S_MG_RD,
      S_MG_CMP,
      S_PR_INIT,
      S_OUT_CHK,
      S_OUT_CAP,
      S_IN_CHK,
      S_IN_ROW,
      S_IN_PUSH,
      S_TAKE_RD,
      S_TAKE_CAP,
      S_DONE_WR,
      S_RESULT
   } state_type;

   typedef struct packed {
      op_type op;
   } dp_cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    num_ok;
      logic    scan_end_p;
      logic    scan_end_a;
      logic    a_end;
      logic    b_end;
      logic    fifo_empty;
      logic    out_free;
   } dp_stat_type;

endpackage
`default_nettype wire

[hdl/cps_chan_if.sv]
// request and response channel interfaces
`default_nettype none
interface cps_req_if;
   import cps_pkg::*;
   logic                valid;
   logic                ready;
   logic [1:0]          command;
   logic [NUMBER_W-1:0] number;
   modport source (output valid, output command, output number, input ready);
   modport sink (input valid, input command, input number, output ready);
endinterface

interface cps_rsp_if;
   import cps_pkg::*;
   logic                valid;
   logic                ready;
   logic [NUMBER_W-1:0] pair_first;
   logic [NUMBER_W-1:0] pair_second;
   logic                pair_valid;
   logic [1:0]          status;
   logic [QCOUNT_W-1:0] queued_count;
   modport source (output valid, output pair_first, output pair_second, output pair_valid,
                   output status, output queued_count, input ready);
   modport sink (input valid, input pair_first, input pair_second, input pair_valid,
                 input status, input queued_count, output ready);
endinterface
`default_nettype wire

[hdl/critical_pair_scheduler_top.sv]
// critical pair scheduler top level
// one command at a time; take is shorter when the queue is empty, remove with a bad
// number skips both list scans, and fill ends in a scan over every ordered pair of
// active numbers; a new command is taken while the previous result waits in the
// output register; synchronous reset clears counts, queue pointers and done-row valid bits
`default_nettype none
module critical_pair_scheduler_top
   import cps_pkg::*;
#(
   parameter int MAX_NUMBERS      = 64,
   parameter int PAIR_QUEUE_DEPTH = 4096
) (
   input wire logic clock,
   input wire logic reset,
   cps_req_if.sink  req_chan,
   cps_rsp_if.source rsp_chan
);

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   cps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (dp_stat),
      .cmd       (dp_cmd)
   );

   cps_datapath #(
      .MAX_NUMBERS      (MAX_NUMBERS),
      .PAIR_QUEUE_DEPTH (PAIR_QUEUE_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (dp_cmd),
      .stat             (dp_stat),
      .req_command      (req_chan.command),
      .req_number       (req_chan.number),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_pair_first   (rsp_chan.pair_first),
      .rsp_pair_second  (rsp_chan.pair_second),
      .rsp_pair_valid   (rsp_chan.pair_valid),
      .rsp_status       (rsp_chan.status),
      .rsp_queued_count (rsp_chan.queued_count)
   );

endmodule
`default_nettype wire

[hdl/cps_ctrl.sv]
// command sequencer of the critical pair scheduler
`default_nettype none
module cps_ctrl
   import cps_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire dp_stat_type stat,
   output dp_cmd_type       cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd.op    = OP_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (stat.cmd)
               CMD_ADD: state_in = S_ADD;
               CMD_REMOVE: state_in = stat.num_ok ? S_RMP_INIT : S_RESULT;
               CMD_FILL: state_in = S_MG_INIT;
               CMD_TAKE: begin
                  if (stat.fifo_empty) begin
                     cmd.op   = OP_TAKE_EMPTY;
                     state_in = S_RESULT;
                  end else begin
                     state_in = S_TAKE_RD;
                  end
               end
            endcase
         end
         S_ADD: begin
            cmd.op   = OP_ADD;
            state_in = S_RESULT;
         end
         S_RMP_INIT: begin
            cmd.op   = OP_SCAN_INIT;
            state_in = S_RMP_RD;
         end
         S_RMP_RD: begin
            if (stat.scan_end_p) begin
               cmd.op   = OP_RMP_END;
               state_in = S_RMA_INIT;
            end else begin
               state_in = S_RMP_CMP;
            end
         end
         S_RMP_CMP: begin
            cmd.op   = OP_RMP_CMP;
            state_in = S_RMP_RD;
         end
         S_RMA_INIT: begin
            cmd.op   = OP_SCAN_INIT;
            state_in = S_RMA_RD;
         end
         S_RMA_RD: begin
            if (stat.scan_end_a) begin
               cmd.op   = OP_RMA_END;
               state_in = S_RESULT;
            end else begin
               state_in = S_RMA_CMP;
            end
         end
         S_RMA_CMP: begin
            cmd.op   = OP_RMA_CMP;
            state_in = S_RMA_RD;
         end
         S_MG_INIT: begin
            cmd.op   = OP_SCAN_INIT;
            state_in = S_MG_RD;
         end
         S_MG_RD: begin
            if (stat.scan_end_p) begin
               cmd.op   = OP_MG_END;
               state_in = S_PR_INIT;
            end else begin
               state_in = S_MG_CMP;
            end
         end
         S_MG_CMP: begin
            cmd.op   = OP_MG_CMP;
            state_in = S_MG_RD;
         end
         S_PR_INIT: begin
            cmd.op   = OP_PR_INIT;
            state_in = S_OUT_CHK;
         end
         S_OUT_CHK: begin
            if (stat.b_end) begin
               state_in = S_RESULT;
            end else begin
               cmd.op   = OP_OUT_RD;
               state_in = S_OUT_CAP;
            end
         end
         S_OUT_CAP: begin
            cmd.op   = OP_OUT_CAP;
            state_in = S_IN_CHK;
         end
         S_IN_CHK: begin
            if (stat.a_end) begin
               cmd.op   = OP_B_INC;
               state_in = S_OUT_CHK;
            end else begin
               cmd.op   = OP_IN_RD;
               state_in = S_IN_ROW;
            end
         end
         S_IN_ROW: begin
            cmd.op   = OP_IN_ROW;
            state_in = S_IN_PUSH;
         end
         S_IN_PUSH: begin
            cmd.op   = OP_IN_PUSH;
            state_in = S_IN_CHK;
         end
         S_TAKE_RD: begin
            cmd.op   = OP_TAKE_RD;
            state_in = S_TAKE_CAP;
         end
         S_TAKE_CAP: begin
            cmd.op   = OP_TAKE_CAP;
            state_in = S_DONE_WR;
         end
         S_DONE_WR: begin
            cmd.op   = OP_DONE_WR;
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (stat.out_free) begin
               cmd.op   = OP_RESULT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule
`default_nettype wire

[hdl/cps_datapath.sv]
// lists, done matrix, pair queue and result register
`default_nettype none
module cps_datapath
   import cps_pkg::*;
#(
   parameter int MAX_NUMBERS      = 64,
   parameter int PAIR_QUEUE_DEPTH = 4096
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire dp_cmd_type          cmd,
   output dp_stat_type              stat,
   input  wire logic [1:0]          req_command,
   input  wire logic [NUMBER_W-1:0] req_number,
   input  wire logic                rsp_ready,
   output logic                     rsp_valid,
   output logic [NUMBER_W-1:0]      rsp_pair_first,
   output logic [NUMBER_W-1:0]      rsp_pair_second,
   output logic                     rsp_pair_valid,
   output logic [1:0]               rsp_status,
   output logic [QCOUNT_W-1:0]      rsp_queued_count
);

   localparam int IDX_W  = $clog2(MAX_NUMBERS);
   localparam int CNT_W  = $clog2(MAX_NUMBERS + 1);
   localparam int NX_W   = NUMBER_W + CNT_W;
   localparam int QA_W   = $clog2(PAIR_QUEUE_DEPTH);
   localparam int FILL_W = $clog2(PAIR_QUEUE_DEPTH + 1);
   localparam int QX_W   = FILL_W + QCOUNT_W;
   localparam int PAIR_W = 2 * NUMBER_W;

   function automatic logic num_ok(input logic [NUMBER_W-1:0] n);
      return (n != '0) && (NX_W'(n) <= NX_W'(MAX_NUMBERS));
   endfunction

   function automatic logic [IDX_W-1:0] num_idx(input logic [NUMBER_W-1:0] n);
      logic [NUMBER_W-1:0] m;
      logic [NX_W-1:0]     t;
      m = n - 1'b1;
      t = NX_W'(m);
      return t[IDX_W-1:0];
   endfunction

   // storage
   logic [NUMBER_W-1:0]    pend_mem [MAX_NUMBERS];
   logic [NUMBER_W-1:0]    act_mem [MAX_NUMBERS];
   logic [MAX_NUMBERS-1:0] done_mem [MAX_NUMBERS];
   logic [PAIR_W-1:0]      fifo_mem [PAIR_QUEUE_DEPTH];

   logic [NUMBER_W-1:0]    pend_rd_ff;
   logic [NUMBER_W-1:0]    act_rd_ff;
   logic [MAX_NUMBERS-1:0] done_rd_ff;
   logic                   done_rv_ff;
   logic [PAIR_W-1:0]      fifo_rd_ff;

   logic                   pend_we;
   logic [IDX_W-1:0]       pend_waddr;
   logic [NUMBER_W-1:0]    pend_wdata;
   logic                   act_we;
   logic [IDX_W-1:0]       act_waddr;
   logic [NUMBER_W-1:0]    act_wdata;
   logic [IDX_W-1:0]       act_raddr;
   logic                   done_we;
   logic [IDX_W-1:0]       done_waddr;
   logic [MAX_NUMBERS-1:0] done_wdata;
   logic [IDX_W-1:0]       done_raddr;
   logic                   fifo_we;
   logic [QA_W-1:0]        fifo_waddr;

   // control state
   logic [CNT_W-1:0]       pcount_ff, pcount_in;
   logic [CNT_W-1:0]       acount_ff, acount_in;
   logic [MAX_NUMBERS-1:0] member_ff, member_in;
   logic [MAX_NUMBERS-1:0] rowv_ff, rowv_in;
   logic [QA_W-1:0]        head_ff, head_in;
   logic [FILL_W-1:0]      fill_ff, fill_in;
   logic [CNT_W-1:0]       k_ff, k_in;
   logic [CNT_W-1:0]       w_ff, w_in;
   logic [CNT_W-1:0]       a_ff, a_in;
   logic [CNT_W-1:0]       b_ff, b_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // payload
   cmd_type                cmd_ff, cmd_in;
   logic [NUMBER_W-1:0]    num_ff, num_in;
   logic [NUMBER_W-1:0]    ni_ff, ni_in;
   logic [NUMBER_W-1:0]    nj_ff, nj_in;
   logic [NUMBER_W-1:0]    first_ff, first_in;
   logic [NUMBER_W-1:0]    second_ff, second_in;
   logic                   pvalid_ff, pvalid_in;
   status_type             status_ff, status_in;
   logic [NUMBER_W-1:0]    o_first_ff, o_first_in;
   logic [NUMBER_W-1:0]    o_second_ff, o_second_in;
   logic                   o_pvalid_ff, o_pvalid_in;
   status_type             o_status_ff, o_status_in;
   logic [QCOUNT_W-1:0]    o_count_ff, o_count_in;

   logic [MAX_NUMBERS-1:0] row_eff;
   logic [FILL_W:0]        pos_sum;
   logic [FILL_W:0]        pos;
   logic [FILL_W-1:0]      head_inc;
   logic [QX_W-1:0]        fill_x;
   logic                   out_free;

   assign row_eff  = done_rv_ff ? done_rd_ff : '0;
   assign pos_sum  = {1'b0, fill_ff} + (FILL_W + 1)'(head_ff);
   assign pos      = (pos_sum >= (FILL_W + 1)'(PAIR_QUEUE_DEPTH)) ?
                     pos_sum - (FILL_W + 1)'(PAIR_QUEUE_DEPTH) : pos_sum;
   assign head_inc = FILL_W'(head_ff) + 1'b1;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // memory ports
   always_ff @(posedge clock) begin
      if (pend_we) begin
         pend_mem[pend_waddr] <= pend_wdata;
      end
      pend_rd_ff <= pend_mem[k_ff[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (act_we) begin
         act_mem[act_waddr] <= act_wdata;
      end
      act_rd_ff <= act_mem[act_raddr];
   end

   always_ff @(posedge clock) begin
      if (done_we) begin
         done_mem[done_waddr] <= done_wdata;
      end
      done_rd_ff <= done_mem[done_raddr];
      done_rv_ff <= rowv_ff[done_raddr];
   end

   always_ff @(posedge clock) begin
      if (fifo_we) begin
         fifo_mem[fifo_waddr] <= {ni_ff, nj_ff};
      end
      fifo_rd_ff <= fifo_mem[head_ff];
   end

   always_comb begin
      pcount_in    = pcount_ff;
      acount_in    = acount_ff;
      member_in    = member_ff;
      rowv_in      = rowv_ff;
      head_in      = head_ff;
      fill_in      = fill_ff;
      k_in         = k_ff;
      w_in         = w_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      cmd_in       = cmd_ff;
      num_in       = num_ff;
      ni_in        = ni_ff;
      nj_in        = nj_ff;
      first_in     = first_ff;
      second_in    = second_ff;
      pvalid_in    = pvalid_ff;
      status_in    = status_ff;
      o_first_in   = o_first_ff;
      o_second_in  = o_second_ff;
      o_pvalid_in  = o_pvalid_ff;
      o_status_in  = o_status_ff;
      o_count_in   = o_count_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      pend_we      = 1'b0;
      pend_waddr   = w_ff[IDX_W-1:0];
      pend_wdata   = pend_rd_ff;
      act_we       = 1'b0;
      act_waddr    = w_ff[IDX_W-1:0];
      act_wdata    = act_rd_ff;
      act_raddr    = k_ff[IDX_W-1:0];
      done_we      = 1'b0;
      done_waddr   = num_idx(first_ff);
      done_wdata   = row_eff | ({{(MAX_NUMBERS - 1){1'b0}}, 1'b1} << num_idx(second_ff));
      done_raddr   = num_idx(act_rd_ff);
      fifo_we      = 1'b0;
      fifo_waddr   = pos[QA_W-1:0];
      fill_x       = QX_W'(fill_ff);
      unique case (cmd.op)
         OP_LOAD: begin
            cmd_in    = cmd_type'(req_command);
            num_in    = req_number;
            status_in = ST_OK;
            first_in  = '0;
            second_in = '0;
            pvalid_in = 1'b0;
         end
         OP_ADD: begin
            if (num_ok(num_ff)) begin
               if (pcount_ff < CNT_W'(MAX_NUMBERS)) begin
                  pend_we    = 1'b1;
                  pend_waddr = pcount_ff[IDX_W-1:0];
                  pend_wdata = num_ff;
                  pcount_in  = CNT_W'(pcount_ff + 1'b1);
               end else begin
                  status_in = ST_FULL;
               end
            end
         end
         OP_TAKE_EMPTY: status_in = ST_EMPTY;
         OP_SCAN_INIT: begin
            k_in = '0;
            w_in = '0;
         end
         OP_RMP_CMP: begin
            if (pend_rd_ff != num_ff) begin
               pend_we = 1'b1;
               w_in    = CNT_W'(w_ff + 1'b1);
            end
            k_in = CNT_W'(k_ff + 1'b1);
         end
         OP_RMA_CMP: begin
            if (act_rd_ff != num_ff) begin
               act_we = 1'b1;
               w_in   = CNT_W'(w_ff + 1'b1);
            end
            k_in = CNT_W'(k_ff + 1'b1);
         end
         OP_RMP_END: pcount_in = w_ff;
         OP_RMA_END: begin
            acount_in                 = w_ff;
            member_in[num_idx(num_ff)] = 1'b0;
         end
         OP_MG_CMP: begin
            if (num_ok(pend_rd_ff) && !member_ff[num_idx(pend_rd_ff)] &&
                (acount_ff < CNT_W'(MAX_NUMBERS))) begin
               act_we                         = 1'b1;
               act_waddr                      = acount_ff[IDX_W-1:0];
               act_wdata                      = pend_rd_ff;
               member_in[num_idx(pend_rd_ff)] = 1'b1;
               acount_in                      = CNT_W'(acount_ff + 1'b1);
            end
            k_in = CNT_W'(k_ff + 1'b1);
         end
         OP_MG_END: pcount_in = '0;
         OP_PR_INIT: b_in = '0;
         OP_OUT_RD: act_raddr = b_ff[IDX_W-1:0];
         OP_OUT_CAP: begin
            nj_in = act_rd_ff;
            a_in  = '0;
         end
         OP_B_INC: b_in = CNT_W'(b_ff + 1'b1);
         OP_IN_RD: act_raddr = a_ff[IDX_W-1:0];
         OP_IN_ROW: ni_in = act_rd_ff;
         OP_IN_PUSH: begin
            if (!row_eff[num_idx(nj_ff)]) begin
               if (fill_ff != FILL_W'(PAIR_QUEUE_DEPTH)) begin
                  fifo_we = 1'b1;
                  fill_in = FILL_W'(fill_ff + 1'b1);
               end else begin
                  status_in = ST_OVERFLOW;
               end
            end
            a_in = CNT_W'(a_ff + 1'b1);
         end
         OP_TAKE_RD: ;
         OP_TAKE_CAP: begin
            first_in   = fifo_rd_ff[PAIR_W-1:NUMBER_W];
            second_in  = fifo_rd_ff[NUMBER_W-1:0];
            pvalid_in  = 1'b1;
            head_in    = (head_inc == FILL_W'(PAIR_QUEUE_DEPTH)) ? '0 : head_inc[QA_W-1:0];
            fill_in    = FILL_W'(fill_ff - 1'b1);
            done_raddr = num_idx(fifo_rd_ff[PAIR_W-1:NUMBER_W]);
         end
         OP_DONE_WR: begin
            if (num_ok(first_ff) && num_ok(second_ff)) begin
               done_we                     = 1'b1;
               rowv_in[num_idx(first_ff)] = 1'b1;
            end
         end
         OP_RESULT: begin
            o_first_in   = first_ff;
            o_second_in  = second_ff;
            o_pvalid_in  = pvalid_ff;
            o_status_in  = status_ff;
            o_count_in   = fill_x[QCOUNT_W-1:0];
            rsp_valid_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pcount_ff    <= '0;
         acount_ff    <= '0;
         member_ff    <= '0;
         rowv_ff      <= '0;
         head_ff      <= '0;
         fill_ff      <= '0;
         k_ff         <= '0;
         w_ff         <= '0;
         a_ff         <= '0;
         b_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pcount_ff    <= pcount_in;
         acount_ff    <= acount_in;
         member_ff    <= member_in;
         rowv_ff      <= rowv_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         k_ff         <= k_in;
         w_ff         <= w_in;
         a_ff         <= a_in;
         b_ff         <= b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      num_ff      <= num_in;
      ni_ff       <= ni_in;
      nj_ff       <= nj_in;
      first_ff    <= first_in;
      second_ff   <= second_in;
      pvalid_ff   <= pvalid_in;
      status_ff   <= status_in;
      o_first_ff  <= o_first_in;
      o_second_ff <= o_second_in;
      o_pvalid_ff <= o_pvalid_in;
      o_status_ff <= o_status_in;
      o_count_ff  <= o_count_in;
   end

   assign stat.cmd        = cmd_ff;
   assign stat.num_ok     = num_ok(num_ff);
   assign stat.scan_end_p = (k_ff == pcount_ff);
   assign stat.scan_end_a = (k_ff == acount_ff);
   assign stat.a_end      = (a_ff == acount_ff);
   assign stat.b_end      = (b_ff == acount_ff);
   assign stat.fifo_empty = (fill_ff == '0);
   assign stat.out_free   = out_free;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pair_first   = o_first_ff;
   assign rsp_pair_second  = o_second_ff;
   assign rsp_pair_valid   = o_pvalid_ff;
   assign rsp_status       = o_status_ff;
   assign rsp_queued_count = o_count_ff;

endmodule
`default_nettype wire

[tb/critical_pair_scheduler_top_tb.sv]
// self-checking testbench of the critical pair scheduler: directed table, random commands
`timescale 1ns / 100ps
`default_nettype none
module critical_pair_scheduler_top_tb;
   import cps_pkg::*;

   localparam int MAXN = 64;
   localparam int QDEPTH = 4096;
   localparam int IDLE_LIMIT = 400000;

   typedef struct packed {
      logic [6:0]  first;
      logic [6:0]  second;
      logic        pvalid;
      status_type  status;
      logic [12:0] qcount;
   } pair_result;

   typedef struct {
      cmd_type    cmd;
      logic [6:0] number;
      bit         typed;
      pair_result want;
   } stim_row;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #10 clock = ~clock;

   cps_req_if req_chan ();
   cps_rsp_if rsp_chan ();

   critical_pair_scheduler_top u_top (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source)
   );

   // scheduler shadow state
   int pend_q[$];
   int act_q[$];
   bit done_bits[1:MAXN][1:MAXN];
   int pair_q[$][2];

   pair_result result_q[$];
   int  errors = 0;
   int  idle_cycles = 0;
   bit  sink_hold = 1'b0;
   bit  calm = 1'b0;
   bit  stim_done = 1'b0;

   function automatic pair_result schedule_cmd(cmd_type cmd, logic [6:0] num);
      pair_result r;
      bit ovf, found;
      int ni, nj;
      int pr[2];
      r = '0;
      r.status = ST_OK;
      ovf = 1'b0;
      case (cmd)
         CMD_ADD: begin
            if (num >= 1 && num <= MAXN) begin
               if (pend_q.size() < MAXN) pend_q.insert(pend_q.size(), int'(num));
               else r.status = ST_FULL;
            end
         end
         CMD_REMOVE: begin
            if (num >= 1 && num <= MAXN) begin
               for (int k = pend_q.size() - 1; k >= 0; k--)
                  if (pend_q[k] == num) pend_q.delete(k);
               for (int k = act_q.size() - 1; k >= 0; k--)
                  if (act_q[k] == num) act_q.delete(k);
            end
         end
         CMD_FILL: begin
            foreach (pend_q[k]) begin
               found = 1'b0;
               foreach (act_q[m]) if (act_q[m] == pend_q[k]) found = 1'b1;
               if (!found && act_q.size() < MAXN) act_q.insert(act_q.size(), pend_q[k]);
            end
            pend_q.delete();
            foreach (act_q[b]) begin
               nj = act_q[b];
               foreach (act_q[a]) begin
                  ni = act_q[a];
                  if (!done_bits[ni][nj]) begin
                     if (pair_q.size() < QDEPTH) begin
                        pr[0] = ni;
                        pr[1] = nj;
                        pair_q.insert(pair_q.size(), pr);
                     end else ovf = 1'b1;
                  end
               end
            end
            if (ovf) r.status = ST_OVERFLOW;
         end
         default: begin
            if (pair_q.size() == 0) r.status = ST_EMPTY;
            else begin
               pr = pair_q[0];
               pair_q.delete(0);
               r.first = 7'(pr[0]);
               r.second = 7'(pr[1]);
               r.pvalid = 1'b1;
               done_bits[pr[0]][pr[1]] = 1'b1;
            end
         end
      endcase
      r.qcount = 13'(pair_q.size());
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      errors++;
      $display("mismatch %s: got %0d, expected %0d", what, got, want);
   endtask

   // result checking
   always @(posedge clock) begin
      pair_result exp_r;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (result_q.size() == 0) report_mismatch("unexpected transfer", 1, 0);
         else begin
            exp_r = result_q[0];
            result_q.delete(0);
            if (rsp_chan.pair_first !== exp_r.first)
               report_mismatch("pair_first", rsp_chan.pair_first, exp_r.first);
            if (rsp_chan.pair_second !== exp_r.second)
               report_mismatch("pair_second", rsp_chan.pair_second, exp_r.second);
            if (rsp_chan.pair_valid !== exp_r.pvalid)
               report_mismatch("pair_valid", rsp_chan.pair_valid, exp_r.pvalid);
            if (rsp_chan.status !== exp_r.status)
               report_mismatch("status", rsp_chan.status, exp_r.status);
            if (rsp_chan.queued_count !== exp_r.qcount)
               report_mismatch("queued_count", rsp_chan.queued_count, exp_r.qcount);
         end
      end
   end

   // receiver ready
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready <= !sink_hold && (calm || $urandom_range(99) >= 14);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else if (!reset) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // valid stays high after a transfer until the next idle stretch or pause
   task automatic send_cmd(cmd_type cmd, logic [6:0] num, bit typed, pair_result want);
      pair_result p;
      while (!calm && $urandom_range(99) < 14) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.command <= cmd;
      req_chan.number <= num;
      do @(posedge clock); while (!req_chan.ready);
      p = schedule_cmd(cmd, num);
      if (typed && p !== want) report_mismatch("directed row", int'(p), int'(want));
      result_q.insert(result_q.size(), p);
      @(negedge clock);
   endtask

   function automatic pair_result mk(int f, int s, int v, status_type st, int q);
      pair_result r;
      r.first = 7'(f);
      r.second = 7'(s);
      r.pvalid = 1'(v);
      r.status = st;
      r.qcount = 13'(q);
      return r;
   endfunction

   function automatic logic [6:0] rand_number();
      int k;
      k = $urandom_range(99);
      if (k < 3) return 7'd0;
      if (k < 6) return 7'($urandom_range(127, 65));
      if (k < 60) return 7'($urandom_range(8, 1));
      return 7'($urandom_range(MAXN, 1));
   endfunction

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (result_q.size() != 0);
   endtask

   initial begin
      stim_row rows[$];
      stim_row r;
      pair_result none;
      cmd_type c;
      int k;
      none = '0;
      req_chan.valid = 1'b0;
      req_chan.command = CMD_ADD;
      req_chan.number = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      r.typed = 1'b1; r.number = 0;
      r.cmd = CMD_TAKE;   r.want = mk(0, 0, 0, ST_EMPTY, 0); rows.insert(rows.size(), r);
      r.cmd = CMD_FILL;   r.want = mk(0, 0, 0, ST_OK, 0);    rows.insert(rows.size(), r);
      r.cmd = CMD_ADD;    r.number = 0;   r.want = mk(0, 0, 0, ST_OK, 0);
      rows.insert(rows.size(), r);
      r.cmd = CMD_ADD;    r.number = 65;  r.want = mk(0, 0, 0, ST_OK, 0);
      rows.insert(rows.size(), r);
      r.cmd = CMD_ADD;    r.number = 127; r.want = mk(0, 0, 0, ST_OK, 0);
      rows.insert(rows.size(), r);
      r.cmd = CMD_ADD;    r.number = 1;   r.want = mk(0, 0, 0, ST_OK, 0);
      rows.insert(rows.size(), r);
      r.cmd = CMD_ADD;    r.number = 64;  r.want = mk(0, 0, 0, ST_OK, 0);
      rows.insert(rows.size(), r);
      r.cmd = CMD_ADD;    r.number = 1;   r.want = mk(0, 0, 0, ST_OK, 0);
      rows.insert(rows.size(), r);
      r.cmd = CMD_FILL;   r.number = 127; r.want = mk(0, 0, 0, ST_OK, 4);
      rows.insert(rows.size(), r);
      r.cmd = CMD_TAKE;   r.number = 0;   r.want = mk(1, 1, 1, ST_OK, 3);
      rows.insert(rows.size(), r);
      r.cmd = CMD_TAKE;   r.want = mk(64, 1, 1, ST_OK, 2); rows.insert(rows.size(), r);
      r.typed = 1'b0;
      r.cmd = CMD_FILL;   rows.insert(rows.size(), r);
      r.cmd = CMD_REMOVE; r.number = 64;  rows.insert(rows.size(), r);
      r.cmd = CMD_REMOVE; r.number = 0;   rows.insert(rows.size(), r);
      r.cmd = CMD_REMOVE; r.number = 100; rows.insert(rows.size(), r);
      r.cmd = CMD_ADD;    r.number = 64;  rows.insert(rows.size(), r);
      r.cmd = CMD_FILL;   rows.insert(rows.size(), r);
      foreach (rows[i]) send_cmd(rows[i].cmd, rows[i].number, rows[i].typed, rows[i].want);
      wait_drained();

      // pending list full, then a fill that overflows the pair queue
      for (int n = 1; n <= MAXN; n++) send_cmd(CMD_ADD, 7'(n), 1'b0, none);
      send_cmd(CMD_ADD, 7'd5, 1'b1, mk(0, 0, 0, ST_FULL, pair_q.size()));
      send_cmd(CMD_FILL, 7'd0, 1'b0, none);
      send_cmd(CMD_FILL, 7'd0, 1'b0, none);

      // receiver holds off while requests keep coming
      fork
         begin
            sink_hold = 1'b1;
            repeat (300) @(negedge clock);
            sink_hold = 1'b0;
         end
         begin
            calm = 1'b1;
            repeat (20) send_cmd(CMD_TAKE, 7'($urandom_range(127)), 1'b0, none);
            calm = 1'b0;
            req_chan.valid <= 1'b0;
            @(negedge clock);
         end
      join
      for (int n = 1; n <= MAXN; n++) send_cmd(CMD_REMOVE, 7'(n), 1'b0, none);
      wait_drained();

      // random commands, mostly add/fill/take runs with small active sets
      for (int i = 0; i < 1650; i++) begin
         if (i == 600) calm = 1'b1;
         if (i == 800) calm = 1'b0;
         if (i == 1000) wait_drained();
         k = $urandom_range(99);
         if (act_q.size() > 10 && k < 50) c = CMD_REMOVE;
         else if (k < 35) c = CMD_ADD;
         else if (k < 45) c = CMD_REMOVE;
         else if (k < 52) c = CMD_FILL;
         else c = CMD_TAKE;
         if (c == CMD_FILL && pair_q.size() > 3000) c = CMD_TAKE;
         send_cmd(c, (c == CMD_ADD || c == CMD_REMOVE) ? rand_number()
                     : 7'($urandom_range(127)), 1'b0, none);
      end

      wait_drained();
      repeat (50) @(posedge clock);
      if (errors == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end
endmodule
`default_nettype wire
